// ===== rtl/fbpa_pkg.sv =====
package fbpa_pkg;

  localparam int ADDR_W = 32;
  localparam int BB_W = 16;
  localparam int TOTAL_W = 7;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DIV_CNT_W = $clog2(ADDR_W);

  // register indexes on the config port
  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
  localparam logic [1:0] REG_BLOCK_TOTAL = 2'd2;

  localparam logic [ADDR_W-1:0]  RST_POOL_BASE   = '0;
  localparam logic [BB_W-1:0]    RST_BLOCK_BYTES = BB_W'(1);
  localparam logic [TOTAL_W-1:0] RST_BLOCK_TOTAL = TOTAL_W'(64);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;

  typedef struct packed {
    logic              done;
    logic              rem_zero;
    logic [ADDR_W-1:0] quo;
  } div_res_t;

endpackage

// ===== rtl/fbpa_busy_mem.sv =====
module fbpa_busy_mem #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem_r [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fbpa_div.sv =====
module fbpa_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
  input  logic [fbpa_pkg::BB_W-1:0]   divisor,
  output fbpa_pkg::div_res_t          res
);
  import fbpa_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [BB_W-1:0]      rem_r;
  logic [ADDR_W-1:0]    dq_r;

  logic [BB_W:0]   sh;
  logic [BB_W-1:0] rem_nxt;
  logic            qbit;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    sh = {rem_r, dq_r[ADDR_W-1]};
    if (sh >= {1'b0, divisor}) begin
      qbit = 1'b1;
      rem_nxt = BB_W'(sh - {1'b0, divisor});
    end else begin
      qbit = 1'b0;
      rem_nxt = sh[BB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        dq_r <= dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dq_r <= {dq_r[ADDR_W-2:0], qbit};
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(ADDR_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.rem_zero = (rem_r == '0);
  assign res.quo = dq_r;

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// Fixed-size block pool with next-fit allocation. One busy bit per block sits in a
// small memory; after reset a clearing pass over all MAX_BLOCKS busy bits runs before
// the first request is taken (register writes are taken throughout). An allocate walks
// the busy bits from the next-fit pointer one block per cycle and looks at up to the
// live block count of blocks. A free divides the offset from pool_base by block_bytes
// with a bit-serial divider of 32 steps. One request is in flight at a time and
// in_stall stays high while it runs; a finished result sits in the output register
// while the next request is taken. Frees of unaligned or out-of-range addresses, or
// with block_bytes or block_total zero, report bad address and change nothing.
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [fbpa_pkg::ADDR_W-1:0]   in_release_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [fbpa_pkg::ADDR_W-1:0]   out_granted_address,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbpa_pkg::CFG_AW-1:0]   paddr,
  input  logic [fbpa_pkg::CFG_DW-1:0]   pwdata,
  output logic [fbpa_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import fbpa_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int PROD_W = BB_W + IDX_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_ADDR, S_DIV, S_PUSH} state_t;

  state_t             state_r;
  logic [ADDR_W-1:0]  pool_base_r;
  logic [BB_W-1:0]    block_bytes_r;
  logic [TOTAL_W-1:0] block_total_r;
  logic [IDX_W-1:0]   clr_r;
  logic [IDX_W-1:0]   nf_r;
  logic [IDX_W-1:0]   chk_r;
  logic [IDX_W-1:0]   ahead_r;
  logic [CNT_W-1:0]   steps_r;
  logic [PROD_W-1:0]  prod_r;
  logic [1:0]         res_status_r;
  logic [ADDR_W-1:0]  res_addr_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [ADDR_W-1:0]  out_addr_r;

  logic [CNT_W-1:0]   cnt;
  logic [IDX_W-1:0]   ptr0;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic               mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic               mem_rdata;
  logic               div_start;
  logic               div_ok;
  div_res_t           div_res;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] s;
    s = CNT_W'(x) + CNT_W'(1);
    if (s == n) return '0;
    return IDX_W'(s);
  endfunction

  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_POOL_BASE:   prdata = CFG_DW'(pool_base_r);
      REG_BLOCK_BYTES: prdata = CFG_DW'(block_bytes_r);
      REG_BLOCK_TOTAL: prdata = CFG_DW'(block_total_r);
      default:         prdata = '0;
    endcase
  end

  // live block count, saturated to the built depth
  always_comb begin
    if (32'(block_total_r) > 32'(MAX_BLOCKS)) cnt = CNT_W'(MAX_BLOCKS);
    else cnt = CNT_W'(block_total_r);
  end

  assign ptr0 = (CNT_W'(nf_r) >= cnt) ? '0 : nf_r;

  assign div_start = (state_r == S_IDLE) && in_valid && (in_kind == KIND_FREE) &&
                     (cnt != '0) && (block_bytes_r != '0);
  assign div_ok = div_res.rem_zero && (div_res.quo < ADDR_W'(cnt));

  fbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_release_address - pool_base_r),
    .divisor  (block_bytes_r),
    .res      (div_res)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = chk_r;
    mem_wdata = 1'b0;
    mem_raddr = ahead_r;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_r;
      end
      S_IDLE: begin
        mem_raddr = ptr0;
      end
      S_SCAN: begin
        if (!mem_rdata) begin
          mem_we = 1'b1;
          mem_wdata = 1'b1;
        end
      end
      S_DIV: begin
        mem_we = div_res.done && div_ok;
        mem_waddr = div_res.quo[IDX_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  fbpa_busy_mem #(.DEPTH(MAX_BLOCKS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      nf_r <= '0;
      out_valid_r <= 1'b0;
      pool_base_r <= RST_POOL_BASE;
      block_bytes_r <= RST_BLOCK_BYTES;
      block_total_r <= RST_BLOCK_TOTAL;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_POOL_BASE:   pool_base_r <= pwdata[ADDR_W-1:0];
          REG_BLOCK_BYTES: block_bytes_r <= pwdata[BB_W-1:0];
          REG_BLOCK_TOTAL: block_total_r <= pwdata[TOTAL_W-1:0];
          default: ;
        endcase
      end

      // the push state reloads the beat itself
      if (out_valid_r && !out_stall && (state_r != S_PUSH)) out_valid_r <= 1'b0;

      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IDX_W'(1);
          if (clr_r == IDX_W'(MAX_BLOCKS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            if (in_kind == KIND_ALLOC) begin
              if (cnt == '0) begin
                res_status_r <= STAT_EMPTY;
                res_addr_r <= '0;
                state_r <= S_PUSH;
              end else begin
                chk_r <= ptr0;
                ahead_r <= wrap_inc(ptr0, cnt);
                steps_r <= '0;
                state_r <= S_SCAN;
              end
            end else if (div_start) begin
              state_r <= S_DIV;
            end else begin
              res_status_r <= STAT_BAD;
              res_addr_r <= '0;
              state_r <= S_PUSH;
            end
          end
        end
        S_SCAN: begin
          // read data of chk_r is here; the read of ahead_r is already issued
          if (!mem_rdata) begin
            nf_r <= chk_r;
            prod_r <= {{BB_W{1'b0}}, chk_r} * {{IDX_W{1'b0}}, block_bytes_r};
            state_r <= S_ADDR;
          end else if ((steps_r + CNT_W'(1)) == cnt) begin
            nf_r <= wrap_inc(chk_r, cnt);
            res_status_r <= STAT_EMPTY;
            res_addr_r <= '0;
            state_r <= S_PUSH;
          end else begin
            chk_r <= ahead_r;
            ahead_r <= wrap_inc(ahead_r, cnt);
            steps_r <= steps_r + CNT_W'(1);
          end
        end
        S_ADDR: begin
          res_status_r <= STAT_OK;
          res_addr_r <= pool_base_r + ADDR_W'(prod_r);
          state_r <= S_PUSH;
        end
        S_DIV: begin
          if (div_res.done) begin
            res_status_r <= div_ok ? STAT_OK : STAT_BAD;
            res_addr_r <= '0;
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_status_r <= res_status_r;
            out_addr_r <= res_addr_r;
            state_r <= S_IDLE;
          end else begin
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_granted_address = out_addr_r;

endmodule

// ===== rtl/fbpa_chk.sv =====
module fbpa_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  out_status,
  input logic [fbpa_pkg::ADDR_W-1:0] out_granted_address
);
  import fbpa_pkg::*;

  // the block stalls its input after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK) || (out_status == STAT_EMPTY) ||
                  (out_status == STAT_BAD))
    else $error("undefined status code");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_granted_address == '0)
    else $error("failed request carries an address");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
                               $stable(out_granted_address))
    else $error("stalled result beat changed");

endmodule

bind fixed_block_pool_allocator fbpa_chk u_fbpa_chk (.*);
